FILE: rtl/sliding_window_mean_median_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sliding window mean/median block
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEAN_MEDIAN_ASSERT_SVH

// same-cycle implication
`define SWMM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SWMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/swmm_pkg.sv
// ---------------------------------------------------------------------------
// swmm_pkg
// Shared constants and types for the sliding window mean/median block.
// ---------------------------------------------------------------------------
`default_nettype none

package swmm_pkg;

   // window geometry
   localparam int WINDOW      = 10;
   localparam int SAMPLE_W    = 16;
   localparam int HELD_W      = 4;
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int IDX_W       = $clog2(WINDOW);

   // running sum and the shared step counter of the back end
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW);
   localparam int STEPS       = (WINDOW > SUM_W) ? WINDOW : SUM_W;
   localparam int STEP_W      = $clog2(STEPS);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // one classified request
   typedef struct packed {
      logic [SAMPLE_W-1:0] latency_sample;
      logic                replace;   // window full, oldest sample drops out
      logic [CNT_W-1:0]    held;      // samples held after this request
   } swmm_cmd_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } swmm_qstat_type;

endpackage

`default_nettype wire

FILE: rtl/swmm_front.sv
// ---------------------------------------------------------------------------
// swmm_front
// Accepts requests, tracks the fill level and tags each as fill or replace.
// ---------------------------------------------------------------------------
`default_nettype none

module swmm_front import swmm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [SAMPLE_W-1:0] req_latency_sample,
   output logic                     req_stall,
   input  wire swmm_qstat_type      qstat,
   output logic                     push,
   output swmm_cmd_type             push_cmd
);

   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             full_win;

   // stall only on a full queue
   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;
   assign full_win  = (fill_ff == CNT_W'(WINDOW));

   // classify the request
   always_comb begin
      push_cmd.latency_sample = req_latency_sample;
      push_cmd.replace        = full_win;
      push_cmd.held           = full_win ? fill_ff : fill_ff + CNT_W'(1);
      fill_in                 = fill_ff;
      if (push && !full_win) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swmm_queue.sv
// ---------------------------------------------------------------------------
// swmm_queue
// Short FIFO of classified requests between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module swmm_queue import swmm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire swmm_cmd_type  push_cmd,
   input  wire logic          pop,
   output swmm_cmd_type       pop_cmd,
   output swmm_qstat_type     qstat
);

   swmm_cmd_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff;
   logic [QUEUE_CW-1:0] count_in;

   assign pop_cmd     = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   // pointer and level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/swmm_back.sv
// ---------------------------------------------------------------------------
// swmm_back
// Window store, running sum, serial divider and transposition sorter.
// ---------------------------------------------------------------------------
`default_nettype none

module swmm_back import swmm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire swmm_qstat_type      qstat,
   input  wire swmm_cmd_type        pop_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_mean_latency,
   output logic [SAMPLE_W-1:0]      rsp_median_latency,
   output logic [HELD_W-1:0]        rsp_samples_held
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_MED_LO,
      ST_MED_HI,
      ST_DONE
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;
   logic [CNT_W-1:0]    n_ff;
   logic [CNT_W-1:0]    n_in;
   logic [STEP_W-1:0]   step_ff;
   logic [STEP_W-1:0]   step_in;
   logic [SUM_W-1:0]    quot_ff;
   logic [SUM_W-1:0]    quot_in;
   logic [CNT_W-1:0]    rem_ff;
   logic [CNT_W-1:0]    rem_in;
   logic [SAMPLE_W-1:0] med_a_ff;
   logic [SAMPLE_W-1:0] med_a_in;
   logic [SAMPLE_W-1:0] med_ff;
   logic [SAMPLE_W-1:0] med_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic [SAMPLE_W-1:0] rsp_mean_in;
   logic [SAMPLE_W-1:0] rsp_median_ff;
   logic [SAMPLE_W-1:0] rsp_median_in;
   logic [HELD_W-1:0]   rsp_held_ff;
   logic [HELD_W-1:0]   rsp_held_in;

   logic [SAMPLE_W-1:0] win_ff  [WINDOW];
   logic [SAMPLE_W-1:0] win_in  [WINDOW];
   logic [SAMPLE_W-1:0] sort_ff [WINDOW];
   logic [SAMPLE_W-1:0] sort_in [WINDOW];

   logic [SUM_W-1:0]    drop;
   logic [CNT_W:0]      trial;
   logic                div_active;
   logic [CNT_W-1:0]    lo_pos;
   logic [CNT_W-1:0]    hi_pos;
   logic [IDX_W-1:0]    rd_idx;
   logic [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W:0]   mid_sum;

   assign pop                = (state_ff == ST_IDLE) && !qstat.empty;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mean_latency   = rsp_mean_ff;
   assign rsp_median_latency = rsp_median_ff;
   assign rsp_samples_held   = rsp_held_ff;

   // running sum: add new sample, drop the oldest once the window is full
   assign drop   = pop_cmd.replace ? SUM_W'(win_ff[WINDOW-1]) : '0;

   // divider step, one quotient bit per cycle
   assign trial      = {rem_ff, quot_ff[SUM_W-1]};
   assign div_active = ({1'b0, step_ff} < (STEP_W+1)'(SUM_W));

   // middle pair positions; equal for an odd count
   assign lo_pos  = (n_ff - CNT_W'(1)) >> 1;
   assign hi_pos  = n_ff >> 1;
   assign rd_idx  = (state_ff == ST_MED_LO) ? lo_pos[IDX_W-1:0] : hi_pos[IDX_W-1:0];
   assign rd_data = sort_ff[rd_idx];
   assign mid_sum = {1'b0, med_a_ff} + {1'b0, rd_data};

   // next-state and datapath control
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      step_in       = step_ff;
      quot_in       = quot_ff;
      rem_in        = rem_ff;
      med_a_in      = med_a_ff;
      med_in        = med_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mean_in   = rsp_mean_ff;
      rsp_median_in = rsp_median_ff;
      rsp_held_in   = rsp_held_ff;
      win_in        = win_ff;
      sort_in       = sort_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               sum_in     = sum_ff + SUM_W'(pop_cmd.latency_sample) - drop;
               n_in       = pop_cmd.held;
               win_in[0]  = pop_cmd.latency_sample;
               sort_in[0] = pop_cmd.latency_sample;
               for (int i = 1; i < WINDOW; i++) begin
                  win_in[i]  = win_ff[i-1];
                  sort_in[i] = win_ff[i-1];
               end
               quot_in  = sum_ff + SUM_W'(pop_cmd.latency_sample) - drop;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_RUN;
            end
         end

         ST_RUN: begin
            // odd-even transposition pass over the held entries
            for (int i = 0; i < WINDOW - 1; i++) begin
               if ((1'(i) == step_ff[0]) && (CNT_W'(i + 1) < n_ff) &&
                   (sort_ff[i] > sort_ff[i+1])) begin
                  sort_in[i]   = sort_ff[i+1];
                  sort_in[i+1] = sort_ff[i];
               end
            end
            if (div_active) begin
               if (trial >= {1'b0, n_ff}) begin
                  rem_in  = CNT_W'(trial - {1'b0, n_ff});
                  quot_in = {quot_ff[SUM_W-2:0], 1'b1};
               end else begin
                  rem_in  = trial[CNT_W-1:0];
                  quot_in = {quot_ff[SUM_W-2:0], 1'b0};
               end
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = ST_MED_LO;
            end
         end

         ST_MED_LO: begin
            med_a_in = rd_data;
            state_in = ST_MED_HI;
         end

         ST_MED_HI: begin
            med_in   = mid_sum[SAMPLE_W:1];
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_mean_in   = quot_ff[SAMPLE_W-1:0];
               rsp_median_in = med_ff;
               rsp_held_in   = HELD_W'(n_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         n_ff         <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_mean_ff   <= rsp_mean_in;
      rsp_median_ff <= rsp_median_in;
      rsp_held_ff   <= rsp_held_in;
   end

   // payload: window, sorter lanes, divider and median registers
   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      sort_ff  <= sort_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      med_a_ff <= med_a_in;
      med_ff   <= med_in;
   end

endmodule

`default_nettype wire

FILE: rtl/sliding_window_mean_median.sv
// An accepted request waits in the queue until the back end is idle; the back end
// handles one request at a time: load, its step counter (SUM_W = 20 divider steps,
// which also cover the 10 sort passes), median read and result on rsp_valid.
// Reset clears the fill level, running sum, queue and output valid;
// the sample window itself is not cleared and needs no sweep.
// ---------------------------------------------------------------------------
// sliding_window_mean_median
// Mean and median over the most recent latency samples, one result per request.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_mean_median_assert.svh"

module sliding_window_mean_median import swmm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_latency_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [SAMPLE_W-1:0]      rsp_mean_latency,
   output logic [SAMPLE_W-1:0]      rsp_median_latency,
   output logic [HELD_W-1:0]        rsp_samples_held
);

   swmm_qstat_type qstat;
   swmm_cmd_type   push_cmd;
   swmm_cmd_type   pop_cmd;
   logic           push;
   logic           pop;

   // front end: accept and classify
   swmm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_latency_sample (req_latency_sample),
      .req_stall          (req_stall),
      .qstat              (qstat),
      .push               (push),
      .push_cmd           (push_cmd)
   );

   // decoupling queue
   swmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   // back end: window update, sort and divide
   swmm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .qstat              (qstat),
      .pop_cmd            (pop_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean_latency   (rsp_mean_latency),
      .rsp_median_latency (rsp_median_latency),
      .rsp_samples_held   (rsp_samples_held)
   );

   // checks
   `SWMM_ASSERT_IMPLY(a_push_not_full, clock, reset, push, !qstat.full, "push into full queue")
   `SWMM_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `SWMM_ASSERT_IMPLY(a_held_range, clock, reset, push,
      (push_cmd.held != '0) && (push_cmd.held <= CNT_W'(WINDOW)), "held count out of range")
   `SWMM_ASSERT_NEXT(a_one_at_a_time, clock, reset, pop, !pop, "back end popped while busy")

endmodule

`default_nettype wire
